// ===== rtl/ira_pkg.sv =====
`default_nettype none
package ira_pkg;

	localparam int NUM_W = 6;
	localparam int ST_W  = 2;

	localparam logic [ST_W-1:0] ST_OK       = 2'd0;
	localparam logic [ST_W-1:0] ST_DROPPED  = 2'd1;
	localparam logic [ST_W-1:0] ST_REVERSED = 2'd2;

	typedef struct packed {
		logic load;
		logic init;
		logic scan;
		logic fetch;
		logic apply;
		logic out;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic sweep_done;
		logic out_last;
	} sts_t;

endpackage
`default_nettype wire

// ===== rtl/ira_datapath.sv =====
`default_nettype none
module ira_datapath #(
	parameter int MAX_CUSTOMERS = 32,
	parameter int DAY_BITS      = 30
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ira_pkg::cmd_t               cmd,
	output ira_pkg::sts_t               sts,
	input  logic [DAY_BITS-1:0]         arrival_day,
	input  logic [DAY_BITS-1:0]         departure_day,
	output logic                        valid,
	output logic [ira_pkg::NUM_W-1:0]   customer_number,
	output logic [ira_pkg::NUM_W-1:0]   room_number,
	output logic [ira_pkg::NUM_W-1:0]   rooms_needed,
	output logic                        last_result,
	output logic [ira_pkg::ST_W-1:0]    status
);
	import ira_pkg::*;

	localparam int IW = (MAX_CUSTOMERS > 1) ? $clog2(MAX_CUSTOMERS) : 1;
	localparam int CW = $clog2(MAX_CUSTOMERS + 1);
	localparam int EW = CW + 1;
	localparam int KW = DAY_BITS + 1 + IW;
	localparam logic [CW-1:0] MAX_C = CW'(MAX_CUSTOMERS);

	logic [DAY_BITS-1:0] arr_mem  [MAX_CUSTOMERS];
	logic [DAY_BITS-1:0] dep_mem  [MAX_CUSTOMERS];
	logic [NUM_W-1:0]    asg_mem  [MAX_CUSTOMERS];
	logic [NUM_W-1:0]    fifo_mem [MAX_CUSTOMERS];

	logic [CW-1:0]            load_cnt_q;
	logic [1:0]               flags_q;
	logic [EW-1:0]            scan_e_q;
	logic [EW-1:0]            e_s1;
	logic                     scan_vld_s1;
	logic [DAY_BITS-1:0]      arr_rd_q;
	logic [DAY_BITS-1:0]      dep_rd_q;
	logic [KW-1:0]            best_key_q;
	logic [KW-1:0]            prev_key_q;
	logic                     found_q;
	logic                     first_q;
	logic [EW-1:0]            sel_cnt_q;
	logic [CW-1:0]            head_q;
	logic [CW-1:0]            tail_q;
	logic [NUM_W-1:0]         room_total_q;
	logic [MAX_CUSTOMERS-1:0] has_room_q;
	logic [NUM_W-1:0]         asg_rd_q;
	logic [NUM_W-1:0]         fifo_rd_q;
	logic [CW-1:0]            out_k_q;
	logic                     out_vld_q;
	logic [NUM_W-1:0]         cust_q;
	logic                     last_q;
	logic [ST_W-1:0]          status_q;

	logic [EW-1:0]       ev_total;
	logic [DAY_BITS-1:0] cand_day;
	logic [KW-1:0]       cand_key;
	logic [IW-1:0]       best_c;
	logic                best_dep;
	logic [IW-1:0]       asg_addr;
	logic [NUM_W-1:0]    new_room;
	logic [ST_W-1:0]     cur_status;
	logic                out_last;
	logic                fifo_empty;

	// events: even index = arrival, odd = departure of customer index/2
	assign ev_total   = {load_cnt_q, 1'b0};
	assign cand_day   = e_s1[0] ? dep_rd_q : arr_rd_q;
	assign cand_key   = {cand_day, e_s1[0], e_s1[IW:1]};
	assign best_c     = best_key_q[IW-1:0];
	assign best_dep   = best_key_q[IW];
	assign asg_addr   = cmd.out ? out_k_q[IW-1:0] : best_c;
	assign fifo_empty = (head_q == tail_q);
	assign new_room   = fifo_empty ? NUM_W'(room_total_q + 1'b1) : fifo_rd_q;
	assign cur_status = flags_q[1] ? ST_REVERSED : (flags_q[0] ? ST_DROPPED : ST_OK);
	assign out_last   = (CW'(out_k_q + 1'b1) == load_cnt_q);

	assign sts.scan_done  = (scan_e_q == ev_total) && !scan_vld_s1;
	assign sts.sweep_done = (EW'(sel_cnt_q + 1'b1) == ev_total);
	assign sts.out_last   = out_last;

	always_ff @(posedge clk) begin
		if (cmd.load && (load_cnt_q < MAX_C)) begin
			arr_mem[load_cnt_q[IW-1:0]] <= arrival_day;
			dep_mem[load_cnt_q[IW-1:0]] <= departure_day;
		end
		if (cmd.scan && (scan_e_q != ev_total)) begin
			arr_rd_q <= arr_mem[scan_e_q[IW:1]];
			dep_rd_q <= dep_mem[scan_e_q[IW:1]];
		end
		if (cmd.apply && !best_dep) begin
			asg_mem[best_c] <= new_room;
		end
		if (cmd.fetch || cmd.out) begin
			asg_rd_q <= asg_mem[asg_addr];
		end
		if (cmd.apply && best_dep && has_room_q[best_c] && (tail_q < MAX_C)) begin
			fifo_mem[tail_q[IW-1:0]] <= asg_rd_q;
		end
		if (cmd.fetch) begin
			fifo_rd_q <= fifo_mem[head_q[IW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_cnt_q   <= '0;
			flags_q      <= '0;
			scan_e_q     <= '0;
			e_s1         <= '0;
			scan_vld_s1  <= 1'b0;
			best_key_q   <= '0;
			prev_key_q   <= '0;
			found_q      <= 1'b0;
			first_q      <= 1'b1;
			sel_cnt_q    <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			room_total_q <= '0;
			has_room_q   <= '0;
			out_k_q      <= '0;
			out_vld_q    <= 1'b0;
			cust_q       <= '0;
			last_q       <= 1'b0;
			status_q     <= ST_OK;
		end else begin
			out_vld_q <= 1'b0;
			if (cmd.load) begin
				if (load_cnt_q < MAX_C) begin
					load_cnt_q <= CW'(load_cnt_q + 1'b1);
					if (departure_day < arrival_day) begin
						flags_q[1] <= 1'b1;
					end
				end else begin
					flags_q[0] <= 1'b1;
				end
			end
			if (cmd.init) begin
				scan_e_q     <= '0;
				scan_vld_s1  <= 1'b0;
				found_q      <= 1'b0;
				first_q      <= 1'b1;
				sel_cnt_q    <= '0;
				head_q       <= '0;
				tail_q       <= '0;
				room_total_q <= '0;
				has_room_q   <= '0;
				out_k_q      <= '0;
			end
			if (cmd.scan) begin
				if (scan_e_q != ev_total) begin
					e_s1        <= scan_e_q;
					scan_vld_s1 <= 1'b1;
					scan_e_q    <= EW'(scan_e_q + 1'b1);
				end else begin
					scan_vld_s1 <= 1'b0;
				end
				// smallest key strictly above the last one taken
				if (scan_vld_s1 && (first_q || (cand_key > prev_key_q)) &&
				    (!found_q || (cand_key < best_key_q))) begin
					best_key_q <= cand_key;
					found_q    <= 1'b1;
				end
			end
			if (cmd.fetch) begin
				prev_key_q <= best_key_q;
				first_q    <= 1'b0;
			end
			if (cmd.apply) begin
				sel_cnt_q   <= EW'(sel_cnt_q + 1'b1);
				scan_e_q    <= '0;
				scan_vld_s1 <= 1'b0;
				found_q     <= 1'b0;
				if (best_dep) begin
					// a customer with no room yet frees nothing
					if (has_room_q[best_c] && (tail_q < MAX_C)) begin
						tail_q <= CW'(tail_q + 1'b1);
					end
				end else begin
					has_room_q[best_c] <= 1'b1;
					if (fifo_empty) begin
						room_total_q <= NUM_W'(room_total_q + 1'b1);
					end else begin
						head_q <= CW'(head_q + 1'b1);
					end
				end
			end
			if (cmd.out) begin
				out_vld_q <= 1'b1;
				cust_q    <= NUM_W'(out_k_q + 1'b1);
				last_q    <= out_last;
				status_q  <= cur_status;
				if (out_last) begin
					load_cnt_q <= '0;
					flags_q    <= '0;
				end else begin
					out_k_q <= CW'(out_k_q + 1'b1);
				end
			end
		end
	end

	assign valid           = out_vld_q;
	assign customer_number = cust_q;
	assign room_number     = asg_rd_q;
	assign rooms_needed    = room_total_q;
	assign last_result     = last_q;
	assign status          = status_q;

	a_fifo_order: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= tail_q)
		else $error("free list head passed tail");

	a_sel_found: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fetch |-> found_q)
		else $error("scan ended without a next event");

	a_room_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> ((asg_rd_q != '0) && (asg_rd_q <= room_total_q)))
		else $error("room number outside opened rooms");

endmodule
`default_nettype wire

// ===== rtl/ira_ctrl.sv =====
`default_nettype none
module ira_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          last_customer,
	input  ira_pkg::sts_t sts,
	output ira_pkg::cmd_t cmd,
	output logic          busy
);
	import ira_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INIT,
		S_SCAN,
		S_FETCH,
		S_APPLY,
		S_OUT
	} state_t;

	state_t state_q;
	logic   busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start && last_customer) begin
						state_q <= S_INIT;
						busy_q  <= 1'b1;
					end
				end
				S_INIT: state_q <= S_SCAN;
				S_SCAN: begin
					if (sts.scan_done) begin
						state_q <= S_FETCH;
					end
				end
				S_FETCH: state_q <= S_APPLY;
				S_APPLY: begin
					state_q <= sts.sweep_done ? S_OUT : S_SCAN;
				end
				S_OUT: begin
					if (sts.out_last) begin
						state_q <= S_IDLE;
						busy_q  <= 1'b0;
					end
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		cmd       = '0;
		cmd.load  = start && !busy_q;
		cmd.init  = (state_q == S_INIT);
		cmd.scan  = (state_q == S_SCAN);
		cmd.fetch = (state_q == S_FETCH);
		cmd.apply = (state_q == S_APPLY);
		cmd.out   = (state_q == S_OUT);
	end

	assign busy = busy_q;

endmodule
`default_nettype wire

// ===== rtl/interval_room_allocator_top.sv =====
`default_nettype none
// Loads one interval per accepted start (busy stays low while loading); the
// transfer with last_customer set closes the set. The sweep then picks each
// of the 2n events in order by scanning all stored intervals through the
// single read port of the interval stores, after which n results follow on
// consecutive cycles, each marked by valid for one cycle. The receiver cannot
// stall: results must be taken when valid is high. busy falls as the last
// result is presented.
module interval_room_allocator_top #(
	parameter int MAX_CUSTOMERS = 32,
	parameter int DAY_BITS      = 30
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [DAY_BITS-1:0]       arrival_day,
	input  logic [DAY_BITS-1:0]       departure_day,
	input  logic                      last_customer,
	output logic                      valid,
	output logic [ira_pkg::NUM_W-1:0] customer_number,
	output logic [ira_pkg::NUM_W-1:0] room_number,
	output logic [ira_pkg::NUM_W-1:0] rooms_needed,
	output logic                      last_result,
	output logic [ira_pkg::ST_W-1:0]  status
);
	import ira_pkg::*;

	cmd_t cmd;
	sts_t sts;

	ira_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.last_customer (last_customer),
		.sts           (sts),
		.cmd           (cmd),
		.busy          (busy)
	);

	ira_datapath #(
		.MAX_CUSTOMERS (MAX_CUSTOMERS),
		.DAY_BITS      (DAY_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.arrival_day     (arrival_day),
		.departure_day   (departure_day),
		.valid           (valid),
		.customer_number (customer_number),
		.room_number     (room_number),
		.rooms_needed    (rooms_needed),
		.last_result     (last_result),
		.status          (status)
	);

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
`default_nettype none
module testbench;
	import ira_pkg::*;

	localparam int CAP      = 32;
	localparam int DAYW     = 30;
	localparam int WD_LIMIT = 200000;
	localparam int RAND_ITEMS = 45;
	localparam logic [DAYW-1:0] DAY_MAX = {DAYW{1'b1}};

	typedef struct packed {
		logic [NUM_W-1:0] cust;
		logic [NUM_W-1:0] room;
		logic [NUM_W-1:0] total;
		logic             last;
		logic [ST_W-1:0]  st;
	} room_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [DAYW-1:0] arrival_day = '0;
	logic [DAYW-1:0] departure_day = '0;
	logic last_customer = 1'b0;
	logic valid;
	logic [NUM_W-1:0] customer_number, room_number, rooms_needed;
	logic last_result;
	logic [ST_W-1:0] status;

	interval_room_allocator_top #(.MAX_CUSTOMERS(CAP), .DAY_BITS(DAYW)) DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.arrival_day(arrival_day), .departure_day(departure_day),
		.last_customer(last_customer), .valid(valid),
		.customer_number(customer_number), .room_number(room_number),
		.rooms_needed(rooms_needed), .last_result(last_result), .status(status)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// predictor state for the open set
	logic [DAYW-1:0] arr_q[$];
	logic [DAYW-1:0] dep_q[$];
	logic dropped_flag = 1'b0;
	logic reversed_flag = 1'b0;
	room_result_t expected_rooms[$];
	int mismatches = 0;
	int idle_cycles = 0;

	// Greedy sweep: events by day, arrivals first, then by customer index
	task automatic allocate_rooms();
		int n, i, j, head, total, c;
		logic [DAYW:0] ev_day[$];
		bit ev_dep[$];
		int ev_idx[$];
		int fifo[$];
		int room[CAP];
		bit has_room[CAP];
		logic [DAYW:0] d;
		bit k;
		int x;
		logic [ST_W-1:0] st;
		room_result_t r;
		n = arr_q.size();
		for (i = 0; i < n; i++) begin
			ev_day.insert(ev_day.size(), {1'b0, arr_q[i]});
			ev_dep.insert(ev_dep.size(), 1'b0);
			ev_idx.insert(ev_idx.size(), i);
			ev_day.insert(ev_day.size(), {1'b0, dep_q[i]});
			ev_dep.insert(ev_dep.size(), 1'b1);
			ev_idx.insert(ev_idx.size(), i);
			has_room[i] = 0;
			room[i] = 0;
		end
		for (i = 1; i < ev_day.size(); i++) begin
			d = ev_day[i]; k = ev_dep[i]; x = ev_idx[i];
			j = i;
			while (j > 0 && ((d != ev_day[j-1]) ? (d < ev_day[j-1]) :
					(k != ev_dep[j-1]) ? (k < ev_dep[j-1]) : (x < ev_idx[j-1]))) begin
				ev_day[j] = ev_day[j-1]; ev_dep[j] = ev_dep[j-1]; ev_idx[j] = ev_idx[j-1];
				j--;
			end
			ev_day[j] = d; ev_dep[j] = k; ev_idx[j] = x;
		end
		head = 0;
		total = 0;
		for (i = 0; i < ev_day.size(); i++) begin
			c = ev_idx[i];
			if (ev_dep[i]) begin
				if (has_room[c]) fifo.insert(fifo.size(), room[c]);
			end else if (head == fifo.size()) begin
				total++;
				room[c] = total;
				has_room[c] = 1;
			end else begin
				room[c] = fifo[head];
				head++;
				has_room[c] = 1;
			end
		end
		st = reversed_flag ? ST_REVERSED : dropped_flag ? ST_DROPPED : ST_OK;
		for (i = 0; i < n; i++) begin
			r.cust = NUM_W'(i + 1);
			r.room = NUM_W'(room[i]);
			r.total = NUM_W'(total);
			r.last = (i + 1 == n);
			r.st = st;
			expected_rooms.insert(expected_rooms.size(), r);
		end
		arr_q.delete();
		dep_q.delete();
		dropped_flag = 0;
		reversed_flag = 0;
	endtask

	// start stays high between back-to-back transfers; it drops only here
	// or when waiting for the results
	task automatic gap();
		int g;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: g = 0;
			5, 6, 7, 8: g = $urandom_range(1, 3);
			default: g = $urandom_range(5, 30);
		endcase
		if (g > 0) begin
			start <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic send_interval(input logic [DAYW-1:0] a, input logic [DAYW-1:0] d,
			input logic lst, input bit idle_ok = 1'b1);
		if (idle_ok) gap();
		start <= 1'b1;
		arrival_day <= a;
		departure_day <= d;
		last_customer <= lst;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (arr_q.size() < CAP) begin
			arr_q.insert(arr_q.size(), a);
			dep_q.insert(dep_q.size(), d);
			if (d < a) reversed_flag = 1;
		end else begin
			dropped_flag = 1;
		end
		if (lst) allocate_rooms();
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (expected_rooms.size() != 0) @(posedge clk);
	endtask

	task automatic send_random_set(input int n, input logic [DAYW-1:0] span);
		logic [DAYW-1:0] a, d;
		for (int i = 0; i < n; i++) begin
			a = DAYW'($urandom_range(0, span));
			d = ($urandom_range(0, 15) == 0) ? DAYW'($urandom_range(0, span))
				: a + DAYW'($urandom_range(0, span / 2 + 1));
			send_interval(a, d, i == n - 1, $urandom_range(0, 3) != 0);
		end
	endtask

	task automatic test_extremes();
		send_interval('0, '0, 1'b1);
		send_interval(DAY_MAX, DAY_MAX, 1'b0);
		send_interval('0, DAY_MAX, 1'b0);
		send_interval(30'h2AAAAAAA, 30'h15555555, 1'b1);
		wait_drained();
	endtask

	task automatic test_reuse_and_ties();
		send_interval(30'd1, 30'd3, 1'b0);
		send_interval(30'd3, 30'd5, 1'b0);
		send_interval(30'd4, 30'd6, 1'b0);
		send_interval(30'd6, 30'd9, 1'b0);
		send_interval(30'd10, 30'd10, 1'b1);
		send_interval(30'd9, 30'd2, 1'b0);
		send_interval(30'd5, 30'd5, 1'b1);
		wait_drained();
	endtask

	task automatic test_capacity();
		for (int i = 0; i < CAP + 2; i++)
			send_interval(DAYW'(i), DAYW'(i + 3), i == CAP + 1, 1'b0);
		wait_drained();
		for (int i = 0; i < CAP + 1; i++)
			send_interval(DAYW'(5), DAYW'(i == 3 ? 1 : 9), i == CAP, 1'b0);
		wait_drained();
	endtask

	task automatic test_random();
		int sent;
		sent = 0;
		while (sent < RAND_ITEMS) begin
			int n;
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, CAP) : $urandom_range(1, 8);
			if (n > RAND_ITEMS - sent) n = RAND_ITEMS - sent;
			send_random_set(n, ($urandom_range(0, 3) == 0) ? DAY_MAX : 30'd40);
			sent += n;
		end
		wait_drained();
	endtask

	always @(posedge clk) begin
		room_result_t exp_r;
		if (valid) begin
			if (expected_rooms.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result cust=%0d", customer_number);
			end else begin
				exp_r = expected_rooms.pop_front();
				if (exp_r.cust !== customer_number || exp_r.room !== room_number ||
						exp_r.total !== rooms_needed || exp_r.last !== last_result ||
						exp_r.st !== status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp c%0d r%0d t%0d l%0d s%0d got c%0d r%0d t%0d l%0d s%0d",
							exp_r.cust, exp_r.room, exp_r.total, exp_r.last, exp_r.st,
							customer_number, room_number, rooms_needed, last_result, status);
				end
			end
		end
	end

	// watchdog: cycles with no transfer on either side
	always @(posedge clk) begin
		if (valid || (start && !busy) || !arst_n) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WD_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_reuse_and_ties();
		test_capacity();
		test_random();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_rooms.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
`default_nettype wire
